>>> src/udpsfd_pkg.sv
package udpsfd_pkg;

  // Input transaction: a UDP packet header or an interval tick.
  typedef struct packed {
    logic        op;
    logic [31:0] source_address;
    logic [15:0] source_port;
    logic [15:0] dest_port;
  } in_item_t;

  // Output transaction: one alarm or the closing done item of a tick.
  typedef struct packed {
    logic [2:0]  alarm_kind;
    logic [15:0] measured_value;
    logic [15:0] alarm_port;
    logic [31:0] alarm_source;
    logic        last_of_run;
  } out_item_t;

  // One port table entry as held in the entry memory.
  typedef struct packed {
    logic [15:0] tag;
    logic [31:0] source;
    logic [15:0] count;
  } entry_t;

  localparam logic OP_PACKET = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  localparam logic [2:0] KIND_PORT_SCAN = 3'd0;
  localparam logic [2:0] KIND_FRAGGLE   = 3'd1;
  localparam logic [2:0] KIND_ZERO_PORT = 3'd2;
  localparam logic [2:0] KIND_FLOOD     = 3'd3;
  localparam logic [2:0] KIND_DONE      = 3'd4;

  localparam logic [1:0] CFG_FLOOD_THRESHOLD     = 2'd0;
  localparam logic [1:0] CFG_PORT_SCAN_THRESHOLD = 2'd1;
  localparam logic [1:0] CFG_FRAGGLE_THRESHOLD   = 2'd2;

  localparam logic [15:0] ECHO_PORT    = 16'd7;
  localparam logic [15:0] CHARGEN_PORT = 16'd19;
  localparam logic [15:0] COUNT_MAX    = 16'hFFFF;

  localparam logic [15:0] FLOOD_THRESHOLD_RESET     = 16'd75;
  localparam logic [7:0]  PORT_SCAN_THRESHOLD_RESET = 8'd16;
  localparam logic [15:0] FRAGGLE_THRESHOLD_RESET   = 16'd16;

endpackage

>>> src/udp_port_scan_flood_detector_unit.sv
// Packet transactions: a packet to a port already in the table reads the entry, then writes
// back the raised count in ST_PKT_WR; a new port, a zero source port or an overflow is handled on accept.
// Tick transactions: the accept, the summary states ST_SCAN, ST_FRAGGLE and ST_ZERO, the ST_WALK over
// each table entry and ST_DONE; the states after the accept wait while the output side stalls. An empty table goes
// from the accept straight to ST_DONE.
// Reset clears the control state and loads the threshold defaults; the entry memory is not cleared.
module udp_port_scan_flood_detector_unit
  import udpsfd_pkg::*;
#(
  parameter int PORT_TABLE_DEPTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o,
  input  logic      cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  // Index width for the table, and a count width that can hold the full depth.
  localparam int IDX_W = (PORT_TABLE_DEPTH > 1) ? $clog2(PORT_TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(PORT_TABLE_DEPTH + 1);

  // Sequencer states. A tick walks the summary alarms and then the table, newest first.
  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_PKT_WR   = 3'd1;
  localparam logic [2:0] ST_SCAN     = 3'd2;
  localparam logic [2:0] ST_FRAGGLE  = 3'd3;
  localparam logic [2:0] ST_ZERO     = 3'd4;
  localparam logic [2:0] ST_WALK     = 3'd5;
  localparam logic [2:0] ST_DONE     = 3'd6;
  localparam logic [2:0] ST_UNUSED   = 3'd7;

  logic [2:0] state_q, state_d;

  // Interval state held in flip-flops.
  logic [CNT_W-1:0] used_q, used_d;
  logic             overflow_q, overflow_d;
  logic             zero_seen_q, zero_seen_d;
  logic [15:0]      fraggle_q, fraggle_d;

  // Configuration registers.
  logic [15:0] flood_thr_q;
  logic [7:0]  scan_thr_q;
  logic [15:0] fraggle_thr_q;

  // Walk index during a tick and the entry index of a packet hit.
  logic [IDX_W-1:0] walk_q, walk_d;
  logic [IDX_W-1:0] hit_idx_q, hit_idx_d;

  // The port tags are also kept in flip-flops so that a lookup compares them all at once.
  logic [15:0] tag_q [PORT_TABLE_DEPTH];
  logic        tag_we;

  // Entry memory: one write and one registered read per cycle.
  entry_t           entry_mem_q [PORT_TABLE_DEPTH];
  entry_t           rd_q;
  logic             mem_we, mem_re;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;
  entry_t           mem_wdata;

  // Output register.
  logic      out_valid_q, out_valid_d;
  out_item_t out_q, out_d;
  logic      out_free;
  logic      emit;
  out_item_t emit_data;

  logic                        in_accept;
  logic [PORT_TABLE_DEPTH-1:0] hit;
  logic [IDX_W-1:0]            hit_idx;
  logic [IDX_W-1:0]            newest_idx;
  logic [IDX_W-1:0]            used_idx;
  logic [15:0]                 used_ext;
  logic                        is_fraggle_port;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A new result may be loaded when the output register is empty or is being taken now.
  assign out_free = !out_valid_q || !out_stall_i;

  assign used_ext        = {{(16 - CNT_W){1'b0}}, used_q};
  assign newest_idx      = IDX_W'(used_q - CNT_W'(1));
  assign used_idx        = IDX_W'(used_q);
  assign is_fraggle_port = (in_data_i.dest_port == ECHO_PORT) ||
                           (in_data_i.dest_port == CHARGEN_PORT);

  // Tag compare against every occupied entry; tags are unique, so the lowest hit is the hit.
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < PORT_TABLE_DEPTH; i++) begin
      hit[i] = (CNT_W'(i) < used_q) && (tag_q[i] == in_data_i.dest_port);
    end
    for (int i = PORT_TABLE_DEPTH - 1; i >= 0; i--) begin
      if (hit[i]) begin
        hit_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    used_d      = used_q;
    overflow_d  = overflow_q;
    zero_seen_d = zero_seen_q;
    fraggle_d   = fraggle_q;
    walk_d      = walk_q;
    hit_idx_d   = hit_idx_q;
    tag_we      = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = hit_idx_q;
    mem_raddr   = walk_q;
    mem_wdata   = rd_q;
    emit        = 1'b0;
    emit_data   = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (in_data_i.op == OP_PACKET) begin
            if (in_data_i.source_port == 16'd0) begin
              // A zero source port only marks the interval.
              zero_seen_d = 1'b1;
            end else begin
              if (is_fraggle_port && (fraggle_q != COUNT_MAX)) begin
                fraggle_d = fraggle_q + 16'd1;
              end
              if (|hit) begin
                // Known port: fetch the entry, raise its count next cycle.
                mem_re    = 1'b1;
                mem_raddr = hit_idx;
                hit_idx_d = hit_idx;
                state_d   = ST_PKT_WR;
              end else if (used_q == CNT_W'(PORT_TABLE_DEPTH)) begin
                // Table is full, so the port is not stored and a scan alarm is forced.
                overflow_d = 1'b1;
              end else begin
                // New port: the entry starts with a count of one, no read needed.
                tag_we           = 1'b1;
                mem_we           = 1'b1;
                mem_waddr        = used_idx;
                mem_wdata.tag    = in_data_i.dest_port;
                mem_wdata.source = in_data_i.source_address;
                mem_wdata.count  = 16'd1;
                used_d           = used_q + CNT_W'(1);
              end
            end
          end else if (used_q == '0) begin
            // An empty table reports only the done item and keeps the interval state.
            state_d = ST_DONE;
          end else begin
            // The newest entry is read first; its source labels the summary alarms and it
            // is also the first entry of the flood walk.
            mem_re    = 1'b1;
            mem_raddr = newest_idx;
            walk_d    = newest_idx;
            state_d   = ST_SCAN;
          end
        end
      end

      ST_PKT_WR: begin
        mem_we    = 1'b1;
        mem_waddr = hit_idx_q;
        mem_wdata = rd_q;
        if (rd_q.count != COUNT_MAX) begin
          mem_wdata.count = rd_q.count + 16'd1;
        end
        state_d = ST_IDLE;
      end

      ST_SCAN: begin
        if ((used_ext > {8'd0, scan_thr_q}) || overflow_q) begin
          if (out_free) begin
            emit                     = 1'b1;
            emit_data.alarm_kind     = KIND_PORT_SCAN;
            emit_data.measured_value = used_ext;
            emit_data.alarm_source   = rd_q.source;
            state_d                  = ST_FRAGGLE;
          end
        end else begin
          state_d = ST_FRAGGLE;
        end
      end

      ST_FRAGGLE: begin
        if (fraggle_q > fraggle_thr_q) begin
          if (out_free) begin
            emit                     = 1'b1;
            emit_data.alarm_kind     = KIND_FRAGGLE;
            emit_data.measured_value = fraggle_q;
            emit_data.alarm_source   = rd_q.source;
            state_d                  = ST_ZERO;
          end
        end else begin
          state_d = ST_ZERO;
        end
      end

      ST_ZERO: begin
        if (zero_seen_q) begin
          if (out_free) begin
            emit                   = 1'b1;
            emit_data.alarm_kind   = KIND_ZERO_PORT;
            emit_data.alarm_source = rd_q.source;
            state_d                = ST_WALK;
          end
        end else begin
          state_d = ST_WALK;
        end
      end

      ST_WALK: begin
        // The entry at walk_q sits in the read register; move on once it is reported or skipped.
        if ((rd_q.count <= flood_thr_q) || out_free) begin
          if (rd_q.count > flood_thr_q) begin
            emit                     = 1'b1;
            emit_data.alarm_kind     = KIND_FLOOD;
            emit_data.measured_value = rd_q.count;
            emit_data.alarm_port     = rd_q.tag;
            emit_data.alarm_source   = rd_q.source;
          end
          if (walk_q == '0) begin
            state_d = ST_DONE;
          end else begin
            walk_d    = walk_q - IDX_W'(1);
            mem_re    = 1'b1;
            mem_raddr = walk_q - IDX_W'(1);
          end
        end
      end

      ST_DONE: begin
        if (out_free) begin
          emit                  = 1'b1;
          emit_data.alarm_kind  = KIND_DONE;
          emit_data.last_of_run = 1'b1;
          if (used_q != '0) begin
            used_d      = '0;
            overflow_d  = 1'b0;
            zero_seen_d = 1'b0;
            fraggle_d   = '0;
          end
          state_d = ST_IDLE;
        end
      end

      ST_UNUSED: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_d = out_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_d       = emit_data;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      used_q        <= '0;
      overflow_q    <= 1'b0;
      zero_seen_q   <= 1'b0;
      fraggle_q     <= '0;
      walk_q        <= '0;
      hit_idx_q     <= '0;
      out_valid_q   <= 1'b0;
      flood_thr_q   <= FLOOD_THRESHOLD_RESET;
      scan_thr_q    <= PORT_SCAN_THRESHOLD_RESET;
      fraggle_thr_q <= FRAGGLE_THRESHOLD_RESET;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      overflow_q  <= overflow_d;
      zero_seen_q <= zero_seen_d;
      fraggle_q   <= fraggle_d;
      walk_q      <= walk_d;
      hit_idx_q   <= hit_idx_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_FLOOD_THRESHOLD:     flood_thr_q   <= cfg_data_i;
          CFG_PORT_SCAN_THRESHOLD: scan_thr_q    <= cfg_data_i[7:0];
          CFG_FRAGGLE_THRESHOLD:   fraggle_thr_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (tag_we) begin
      tag_q[used_idx] <= in_data_i.dest_port;
    end
  end

  // Entry memory with a registered read.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      entry_mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= entry_mem_q[mem_raddr];
    end
  end

endmodule
